[hw/rtl/etst_pkg.sv]
package etst_pkg;

    // Field widths fixed by the item format
    localparam int NAME_W     = 4;
    localparam int TIME_W     = 64;
    localparam int COUNT_W    = 32;
    localparam int DISTINCT_W = 5;
    localparam int GMEAN_W    = 32;

    // Names a tag field can carry
    localparam int NAME_SPACE = 1 << NAME_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Item codes
    typedef enum logic
    {
        OP_RECORD = 1'b0,
        OP_READ   = 1'b1
    } opcode_t;

    // One statistics line
    typedef struct packed
    {
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  dmin;
        logic [TIME_W-1:0]  dmax;
        logic [TIME_W-1:0]  dmean;
        logic [TIME_W-1:0]  gmin;
        logic [TIME_W-1:0]  gmax;
        logic [GMEAN_W-1:0] gmean;
    } line_t;

    // Request to the running-mean unit
    typedef struct packed
    {
        logic               start;
        logic [COUNT_W-1:0] count;
        logic [TIME_W-1:0]  mean;
        logic [TIME_W-1:0]  sample;
    } mean_req_t;

    // Answer from the running-mean unit
    typedef struct packed
    {
        logic              done;
        logic [TIME_W-1:0] quot;
    } mean_rsp_t;

endpackage

[hw/rtl/etst_if.sv]
interface etst_req_if;
    import etst_pkg::*;

    logic              valid;
    logic              ready;
    logic              opcode;
    logic [NAME_W-1:0] tag_name;
    logic [TIME_W-1:0] tag_start;
    logic [TIME_W-1:0] tag_end;
    logic [TIME_W-1:0] next_start;
    logic              has_next;

    modport source
    (
        output valid, opcode, tag_name, tag_start, tag_end, next_start, has_next,
        input  ready
    );

    modport sink
    (
        input  valid, opcode, tag_name, tag_start, tag_end, next_start, has_next,
        output ready
    );
endinterface

interface etst_rsp_if;
    import etst_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  line_present;
    logic [DISTINCT_W-1:0] distinct_lines;
    logic [COUNT_W-1:0]    event_count;
    logic [TIME_W-1:0]     min_duration;
    logic [TIME_W-1:0]     max_duration;
    logic [TIME_W-1:0]     mean_duration;
    logic [TIME_W-1:0]     min_gap;
    logic [TIME_W-1:0]     max_gap;
    logic [GMEAN_W-1:0]    mean_gap;

    modport source
    (
        output valid, line_present, distinct_lines, event_count, min_duration,
               max_duration, mean_duration, min_gap, max_gap, mean_gap,
        input  ready
    );

    modport sink
    (
        input  valid, line_present, distinct_lines, event_count, min_duration,
               max_duration, mean_duration, min_gap, max_gap, mean_gap,
        output ready
    );
endinterface

[hw/rtl/event_timing_statistics_table.sv]
// Channel  Modport  Transfer when         Carries
// req      sink     valid && ready        opcode, tag_name, times, has_next
// rsp      source   valid && ready        one statistics line per request
//
// A read passes through READ and then RESP after the transfer; an in-range record
// passes through READ, DUR, GAP, WRITE and RESP, and waits in DUR_WAIT or GAP_WAIT
// for each mean it needs. Each mean runs on the shared unit: start, 32x32 partial
// products and adds, 64 restoring steps, then the quotient is handed back.
// req.ready is high only when the sequencer is idle; a result waits in the
// rsp register while the next request is taken. Reset clears the valid bits
// at once; no clearing pass runs.
module event_timing_statistics_table
    import etst_pkg::*;
#(
    parameter int NAME_COUNT = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    etst_req_if.sink   req,
    etst_rsp_if.source rsp
);

    localparam int IDX_W = $clog2(NAME_COUNT);

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_READ,
        S_DUR,
        S_DUR_WAIT,
        S_GAP,
        S_GAP_WAIT,
        S_WRITE,
        S_RESP
    } state_t;

    state_t                state_reg;
    logic                  op_reg;
    logic                  in_range_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [TIME_W-1:0]     dur_reg;
    logic [TIME_W-1:0]     gap_reg;
    logic                  has_dur_reg;
    logic                  has_gap_reg;
    logic                  was_valid_reg;
    logic                  present_reg;
    line_t                 line_reg;
    logic [DISTINCT_W-1:0] distinct_reg;

    logic                  rsp_valid_reg;
    logic                  rsp_present_reg;
    logic [DISTINCT_W-1:0] rsp_distinct_reg;
    line_t                 rsp_line_reg;

    logic                  accept;
    logic                  req_in_range;
    logic                  tbl_valid;
    line_t                 tbl_line;
    mean_req_t             mreq;
    mean_rsp_t             mrsp;
    logic [COUNT_W-1:0]    cnt_inc;
    line_t                 read_line;
    logic                  rsp_load;

    assign accept       = req.valid && req.ready;
    assign req_in_range = (32'(req.tag_name) < NAME_COUNT);
    assign req.ready    = (state_reg == S_IDLE);

    etst_table #(
        .NAME_COUNT (NAME_COUNT),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (accept && req_in_range),
        .rd_addr  (IDX_W'(req.tag_name)),
        .rd_valid (tbl_valid),
        .rd_line  (tbl_line),
        .wr_en    (state_reg == S_WRITE),
        .wr_addr  (idx_reg),
        .wr_line  (line_reg)
    );

    // Feed the shared unit with the duration or the gap
    always_comb
    begin
        mreq.start  = ((state_reg == S_DUR) && has_dur_reg)
                      || ((state_reg == S_GAP) && has_gap_reg);
        mreq.count  = line_reg.count;
        mreq.mean   = (state_reg == S_DUR) ? line_reg.dmean
                                           : {{(TIME_W-GMEAN_W){1'b0}}, line_reg.gmean};
        mreq.sample = (state_reg == S_DUR) ? dur_reg : gap_reg;
    end

    etst_mean_unit u_mean (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Saturating event count
    assign cnt_inc = (tbl_line.count == COUNT_MAX) ? tbl_line.count
                                                   : tbl_line.count + COUNT_W'(1);

    // Line as read, with the event counted for an in-range record
    always_comb
    begin
        read_line = tbl_line;
        if ((op_reg == OP_RECORD) && in_range_reg)
        begin
            read_line.count = cnt_inc;
        end
    end

    // Load the result register when it is free or being taken
    assign rsp_load = (state_reg == S_RESP) && (!rsp_valid_reg || rsp.ready);

    // Sequencer: state, working line and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            op_reg           <= 1'b0;
            in_range_reg     <= 1'b0;
            idx_reg          <= '0;
            dur_reg          <= '0;
            gap_reg          <= '0;
            has_dur_reg      <= 1'b0;
            has_gap_reg      <= 1'b0;
            was_valid_reg    <= 1'b0;
            present_reg      <= 1'b0;
            line_reg         <= '0;
            distinct_reg     <= '0;
            rsp_valid_reg    <= 1'b0;
            rsp_present_reg  <= 1'b0;
            rsp_distinct_reg <= '0;
            rsp_line_reg     <= '0;
        end
        else
        begin
            // Raise the result when loaded, drop it once taken
            if (rsp_load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    // Capture the request and the two time differences
                    if (accept)
                    begin
                        op_reg       <= req.opcode;
                        in_range_reg <= req_in_range;
                        idx_reg      <= IDX_W'(req.tag_name);
                        dur_reg      <= req.tag_end - req.tag_start;
                        gap_reg      <= req.next_start - req.tag_start;
                        has_dur_reg  <= (req.tag_end != '0);
                        has_gap_reg  <= req.has_next;
                        state_reg    <= S_READ;
                    end
                end
                S_READ:
                begin
                    line_reg      <= read_line;
                    was_valid_reg <= tbl_valid;
                    if ((op_reg == OP_RECORD) && in_range_reg)
                    begin
                        present_reg    <= 1'b1;
                        state_reg      <= S_DUR;
                    end
                    else
                    begin
                        present_reg <= in_range_reg && tbl_valid;
                        state_reg   <= S_RESP;
                    end
                end
                S_DUR:
                begin
                    // Min seeds when still zero
                    if (has_dur_reg)
                    begin
                        if ((line_reg.dmin == '0) || (dur_reg < line_reg.dmin))
                        begin
                            line_reg.dmin <= dur_reg;
                        end
                        if (dur_reg > line_reg.dmax)
                        begin
                            line_reg.dmax <= dur_reg;
                        end
                        state_reg <= S_DUR_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_GAP;
                    end
                end
                S_DUR_WAIT:
                begin
                    if (mrsp.done)
                    begin
                        line_reg.dmean <= mrsp.quot;
                        state_reg      <= S_GAP;
                    end
                end
                S_GAP:
                begin
                    if (has_gap_reg)
                    begin
                        if ((line_reg.gmin == '0) || (gap_reg < line_reg.gmin))
                        begin
                            line_reg.gmin <= gap_reg;
                        end
                        if (gap_reg > line_reg.gmax)
                        begin
                            line_reg.gmax <= gap_reg;
                        end
                        state_reg <= S_GAP_WAIT;
                    end
                    else
                    begin
                        state_reg <= S_WRITE;
                    end
                end
                S_GAP_WAIT:
                begin
                    // Saturate the gap mean to its field
                    if (mrsp.done)
                    begin
                        if (mrsp.quot[TIME_W-1:GMEAN_W] != '0)
                        begin
                            line_reg.gmean <= '1;
                        end
                        else
                        begin
                            line_reg.gmean <= mrsp.quot[GMEAN_W-1:0];
                        end
                        state_reg <= S_WRITE;
                    end
                end
                S_WRITE:
                begin
                    if (!was_valid_reg)
                    begin
                        distinct_reg <= distinct_reg + DISTINCT_W'(1);
                    end
                    state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    // Hold until the result register is free
                    if (rsp_load)
                    begin
                        rsp_present_reg  <= present_reg;
                        rsp_distinct_reg <= distinct_reg;
                        rsp_line_reg     <= present_reg ? line_reg : '0;
                        state_reg        <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.line_present   = rsp_present_reg;
    assign rsp.distinct_lines = rsp_distinct_reg;
    assign rsp.event_count    = rsp_line_reg.count;
    assign rsp.min_duration   = rsp_line_reg.dmin;
    assign rsp.max_duration   = rsp_line_reg.dmax;
    assign rsp.mean_duration  = rsp_line_reg.dmean;
    assign rsp.min_gap        = rsp_line_reg.gmin;
    assign rsp.max_gap        = rsp_line_reg.gmax;
    assign rsp.mean_gap       = rsp_line_reg.gmean;

endmodule

[hw/rtl/etst_table.sv]
module etst_table
    import etst_pkg::*;
#(
    parameter int NAME_COUNT = 16,
    parameter int IDX_W      = $clog2(NAME_COUNT)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output logic             rd_valid,
    output line_t            rd_line,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  line_t            wr_line
);

    line_t                 mem [NAME_COUNT];
    logic [NAME_COUNT-1:0] valid_reg;
    line_t                 rd_data_reg;
    logic                  rd_valid_reg;

    // Line storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_line;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits: cleared by reset, set on first write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // A line never written reads as zero
    assign rd_valid = rd_valid_reg;
    assign rd_line  = rd_valid_reg ? rd_data_reg : '0;

endmodule

[hw/rtl/etst_mean_unit.sv]
module etst_mean_unit
    import etst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  mean_req_t req,
    output mean_rsp_t rsp
);

    localparam int ACC_W  = 2 * TIME_W;
    localparam int HALF_W = TIME_W / 2;
    localparam int STEP_W = $clog2(TIME_W);

    typedef enum logic [2:0]
    {
        U_IDLE,
        U_MUL_LO,
        U_MUL_HI,
        U_ADD_HI,
        U_DIV
    } ustate_t;

    ustate_t              state_reg;
    logic [COUNT_W-1:0]   m_reg;
    logic [COUNT_W-1:0]   c_reg;
    logic [TIME_W-1:0]    a_reg;
    logic [ACC_W-1:0]     acc_reg;
    logic [2*COUNT_W-1:0] prod_reg;
    logic [STEP_W-1:0]    step_reg;
    logic                 done_reg;

    logic [HALF_W-1:0]    mul_b;
    logic [2*COUNT_W-1:0] prod;
    logic [COUNT_W:0]     trial;
    logic [COUNT_W:0]     diff;
    logic                 fits;

    // Shared multiplier takes one half of the old mean per cycle
    assign mul_b = (state_reg == U_MUL_LO) ? a_reg[HALF_W-1:0] : a_reg[TIME_W-1:HALF_W];
    assign prod  = m_reg * mul_b;

    // One restoring division step: remainder sits above the dividend bits
    assign trial = {acc_reg[TIME_W+COUNT_W-1:TIME_W], acc_reg[TIME_W-1]};
    assign diff  = trial - {1'b0, c_reg};
    assign fits  = (trial >= {1'b0, c_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            m_reg     <= '0;
            c_reg     <= '0;
            a_reg     <= '0;
            acc_reg   <= '0;
            prod_reg  <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            // Flag the quotient after the last division step
            done_reg <= (state_reg == U_DIV) && (step_reg == STEP_W'(TIME_W - 1));
            case (state_reg)
                U_IDLE:
                begin
                    // Seed the numerator with the new sample
                    if (req.start)
                    begin
                        m_reg     <= req.count - COUNT_W'(1);
                        c_reg     <= req.count;
                        a_reg     <= req.mean;
                        acc_reg   <= {{TIME_W{1'b0}}, req.sample};
                        state_reg <= U_MUL_LO;
                    end
                end
                U_MUL_LO:
                begin
                    prod_reg  <= prod;
                    state_reg <= U_MUL_HI;
                end
                U_MUL_HI:
                begin
                    acc_reg   <= acc_reg + {{(ACC_W-2*COUNT_W){1'b0}}, prod_reg};
                    prod_reg  <= prod;
                    state_reg <= U_ADD_HI;
                end
                U_ADD_HI:
                begin
                    acc_reg   <= acc_reg
                                 + {{(ACC_W-2*COUNT_W-HALF_W){1'b0}}, prod_reg,
                                    {HALF_W{1'b0}}};
                    step_reg  <= '0;
                    state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    // Shift one quotient bit in per cycle
                    acc_reg <= {{(ACC_W-TIME_W-COUNT_W){1'b0}},
                                (fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0]),
                                acc_reg[TIME_W-2:0], fits};
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(TIME_W - 1))
                    begin
                        state_reg <= U_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = acc_reg[TIME_W-1:0];

endmodule

[hw/rtl/etst_checker.sv]
module etst_checker
    import etst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    input  logic                  req_ready,
    input  logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  logic                  line_present,
    input  logic [DISTINCT_W-1:0] distinct_lines,
    input  logic [COUNT_W-1:0]    event_count,
    input  logic [TIME_W-1:0]     min_duration,
    input  logic [GMEAN_W-1:0]    mean_gap
);

    // One item at a time: no transfer right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request taken while busy");

    // An absent line reports zero statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !line_present)
        |-> (event_count == '0 && min_duration == '0 && mean_gap == '0))
        else $error("absent line with nonzero statistics");

    // A present line has been counted and seen at least once
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && line_present)
        |-> (distinct_lines != '0 && event_count != '0))
        else $error("present line without count");

    // Distinct count never exceeds the name space
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(distinct_lines) <= NAME_SPACE))
        else $error("distinct line count out of range");

    // A stalled result stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(event_count)))
        else $error("result dropped or changed under stall");

endmodule

bind event_timing_statistics_table etst_checker u_etst_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .line_present   (rsp.line_present),
    .distinct_lines (rsp.distinct_lines),
    .event_count    (rsp.event_count),
    .min_duration   (rsp.min_duration),
    .mean_gap       (rsp.mean_gap)
);
